/* sv/mipf_pkg.sv */
// mipf_pkg: shared types, constants and helpers for the masked ip filter table
// used by mipf_entry_ram, mipf_entry_cmp and masked_ip_filter_table
package mipf_pkg;

    localparam int TableDepth = 1024;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);
    localparam int AddrW      = 32;

    localparam logic [AddrW-1:0] AllOnes   = 32'hffff_ffff;
    localparam logic [7:0]       OctetFull = 8'd255;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // the mask of an entry follows from its compare value, so only that is stored
    typedef struct packed {
        logic             valid;
        logic [AddrW-1:0] compare;
    } t_entry;

    typedef struct packed {
        logic            re;
        logic [IdxW-1:0] addr;
    } t_ram_rd;

    typedef struct packed {
        logic            we;
        logic [IdxW-1:0] addr;
        t_entry          data;
    } t_ram_wr;

    // 0xff for every non-zero octet, 0 elsewhere
    function automatic logic [AddrW-1:0] octet_mask(input logic [AddrW-1:0] addr);
        logic [AddrW-1:0] m;
        m = '0;
        for (int k = 0; k < 4; k++) begin
            if (addr[8*k +: 8] != 8'd0) begin
                m[8*k +: 8] = OctetFull;
            end
        end
        return m & AllOnes;
    endfunction

endpackage

/* sv/mipf_entry_ram.sv */
// mipf_entry_ram: filter entry memory, one write and one read port, registered read
// depends on mipf_pkg
module mipf_entry_ram (
    input  logic             i_clk,
    input  mipf_pkg::t_ram_rd i_rd,
    input  mipf_pkg::t_ram_wr i_wr,
    output mipf_pkg::t_entry  o_rdata
);

    mipf_pkg::t_entry r_mem [mipf_pkg::TableDepth];
    mipf_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.re) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mipf_entry_cmp.sv */
// mipf_entry_cmp: shared entry compare unit, decides whether one entry stops the scan
// depends on mipf_pkg
module mipf_entry_cmp (
    input  mipf_pkg::t_cmd              i_cmd,
    input  logic [mipf_pkg::AddrW-1:0]  i_addr,
    input  mipf_pkg::t_entry            i_entry,
    output logic                        o_hit
);

    logic [mipf_pkg::AddrW-1:0] entry_mask;

    assign entry_mask = mipf_pkg::octet_mask(i_entry.compare);

    always_comb begin
        unique case (i_cmd)
            mipf_pkg::CMD_CHECK:
                o_hit = i_entry.valid && ((i_addr & entry_mask) == i_entry.compare);
            // first freed entry
            mipf_pkg::CMD_ADD:
                o_hit = !i_entry.valid;
            // equal compare implies equal mask
            mipf_pkg::CMD_REMOVE:
                o_hit = i_entry.valid && (i_entry.compare == i_addr);
            mipf_pkg::CMD_NOP:
                o_hit = 1'b0;
            default:
                o_hit = 1'b0;
        endcase
    end

endmodule

/* sv/masked_ip_filter_table.sv */
// masked_ip_filter_table: top level, command sequencer, result register and config register
// depends on mipf_pkg, mipf_entry_ram and mipf_entry_cmp
//
// Ordered table of IPv4 filters (check, add, remove), one result per command.
// A command walks the entries appended so far, one entry a cycle through the single
// read port of the entry memory, and stops at the first entry that decides it.
// With n entries appended, a command reads at most n entries (TableDepth on a
// full table) before its result; the unused command code reads none.
// The input stalls for the whole command. A finished result waits in an output
// register, so the next command is taken while it is still stalled. The entry
// memory needs no clearing after reset: only appended entries are ever read.
module masked_ip_filter_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_cmd,
    input  logic [mipf_pkg::AddrW-1:0]  i_address,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_reject,
    output logic [1:0]                  o_status,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                       r_state,    n_state;
    logic                         r_ban_mode, n_ban_mode;
    logic [mipf_pkg::CntW-1:0]    r_used,     n_used;
    mipf_pkg::t_cmd               r_cmd,      n_cmd;
    logic [mipf_pkg::AddrW-1:0]   r_addr,     n_addr;
    logic [mipf_pkg::CntW-1:0]    r_n,        n_n;
    logic [mipf_pkg::CntW-1:0]    r_rd_idx,   n_rd_idx;
    logic                         r_pend,     n_pend;
    logic [mipf_pkg::IdxW-1:0]    r_ev_idx,   n_ev_idx;
    logic                         r_hit,      n_hit;
    logic [mipf_pkg::IdxW-1:0]    r_hit_idx,  n_hit_idx;
    logic                         r_out_valid, n_out_valid;
    logic                         r_reject,   n_reject;
    logic [1:0]                   r_status,   n_status;

    mipf_pkg::t_ram_rd            ram_rd;
    mipf_pkg::t_ram_wr            ram_wr;
    mipf_pkg::t_entry             ram_rdata;
    logic                         cmp_hit;
    logic                         in_xfer;
    logic                         out_free;
    logic                         issue;

    mipf_entry_ram u_ram (
        .i_clk   (i_clk),
        .i_rd    (ram_rd),
        .i_wr    (ram_wr),
        .o_rdata (ram_rdata)
    );

    mipf_entry_cmp u_cmp (
        .i_cmd   (r_cmd),
        .i_addr  (r_addr),
        .i_entry (ram_rdata),
        .o_hit   (cmp_hit)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign issue       = (r_rd_idx < r_n);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_reject    = r_reject;
    assign o_status    = r_status;

    always_comb begin
        n_state     = r_state;
        n_ban_mode  = r_ban_mode;
        n_used      = r_used;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_n         = r_n;
        n_rd_idx    = r_rd_idx;
        n_pend      = r_pend;
        n_ev_idx    = r_ev_idx;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_out_valid = r_out_valid;
        n_reject    = r_reject;
        n_status    = r_status;
        ram_rd      = '{re: 1'b0, addr: r_rd_idx[mipf_pkg::IdxW-1:0]};
        ram_wr      = '{we: 1'b0, addr: r_hit_idx,
                        data: '{valid: 1'b0, compare: r_addr}};

        if (i_cfg_valid && o_cfg_ready) begin
            n_ban_mode = i_cfg_data;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd    = mipf_pkg::t_cmd'(i_cmd);
                    n_addr   = i_address;
                    n_n      = r_used;
                    n_rd_idx = '0;
                    n_pend   = 1'b0;
                    n_hit    = 1'b0;
                    n_state  = (mipf_pkg::t_cmd'(i_cmd) == mipf_pkg::CMD_NOP) ?
                               S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pend && cmp_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_ev_idx;
                    n_pend    = 1'b0;
                    n_state   = S_FINISH;
                end else if (!r_pend && !issue) begin
                    n_state = S_FINISH;
                end else begin
                    // read data for r_rd_idx shows up next cycle
                    ram_rd.re = issue;
                    n_pend    = issue;
                    n_ev_idx  = r_rd_idx[mipf_pkg::IdxW-1:0];
                    if (issue) begin
                        n_rd_idx = r_rd_idx + mipf_pkg::CntW'(1);
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_reject    = 1'b0;
                    n_status    = mipf_pkg::ST_OK;
                    n_state     = S_IDLE;
                    case (r_cmd)
                        mipf_pkg::CMD_CHECK: begin
                            n_reject = r_hit ? r_ban_mode : !r_ban_mode;
                        end
                        mipf_pkg::CMD_ADD: begin
                            ram_wr.data.valid = 1'b1;
                            if (r_hit) begin
                                ram_wr.we = 1'b1;
                            end else if (r_n >= mipf_pkg::CntW'(mipf_pkg::TableDepth)) begin
                                n_status = mipf_pkg::ST_FULL;
                            end else begin
                                ram_wr.we   = 1'b1;
                                ram_wr.addr = r_n[mipf_pkg::IdxW-1:0];
                                n_used      = r_n + mipf_pkg::CntW'(1);
                            end
                        end
                        mipf_pkg::CMD_REMOVE: begin
                            if (r_hit) begin
                                ram_wr.we = 1'b1;
                            end else begin
                                n_status = mipf_pkg::ST_NOT_FOUND;
                            end
                        end
                        default: begin
                            n_reject = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ban_mode  <= 1'b1;
            r_used      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ban_mode  <= n_ban_mode;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_addr    <= n_addr;
        r_n       <= n_n;
        r_rd_idx  <= n_rd_idx;
        r_ev_idx  <= n_ev_idx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_reject  <= n_reject;
        r_status  <= n_status;
    end

endmodule
